@@ rtl/core/scc_pkg.sv @@
// Package for the strided copy chunker: payload structs, status codes,
// controller/datapath command and status bundles. No dependencies.
package scc_pkg;

  localparam int MAX_CHUNKS = 64;
  localparam int DIV_W      = 32;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LAYOUT   = 3'd1;
  localparam logic [2:0] ST_FRAG     = 3'd2;
  localparam logic [2:0] ST_INCOMPAT = 3'd3;
  localparam logic [2:0] ST_MANY     = 3'd5;

  // Output register source
  localparam logic [1:0] OUT_CHUNK = 2'd0;
  localparam logic [1:0] OUT_PASS  = 2'd1;
  localparam logic [1:0] OUT_ERR   = 2'd2;

  // Divider operand selection
  localparam logic [1:0] DIV_CH_FL     = 2'd0;
  localparam logic [1:0] DIV_BIG_SMALL = 2'd1;
  localparam logic [1:0] DIV_CH_BIG    = 2'd2;

  typedef struct packed {
    logic [47:0] src_offset;
    logic [31:0] src_frag_len;
    logic [31:0] src_frag_count;
    logic [31:0] src_stride;
    logic [47:0] dst_offset;
    logic [31:0] dst_frag_len;
    logic [31:0] dst_frag_count;
    logic [31:0] dst_stride;
  } desc_t;

  typedef struct packed {
    logic [47:0] chunk_src_offset;
    logic [31:0] chunk_src_len;
    logic [31:0] chunk_src_count;
    logic [31:0] chunk_src_stride;
    logic [47:0] chunk_dst_offset;
    logic [31:0] chunk_dst_len;
    logic [31:0] chunk_dst_count;
    logic [31:0] chunk_dst_stride;
    logic        last_chunk;
    logic [2:0]  status;
  } chunk_t;

  typedef struct packed {
    logic       load_desc;
    logic       mul_tot;
    logic       div_start;
    logic [1:0] div_sel;
    logic       latch_qa;
    logic       latch_qb;
    logic       set1;
    logic       set2;
    logic       set3;
    logic       emit;
    logic [1:0] out_sel;
    logic [2:0] err_code;
  } cmd_t;

  typedef struct packed {
    logic lay_bad;
    logic ch_zero;
    logic su;
    logic du;
    logic frag_big;
    logic div_done;
    logic div_rem_nz;
    logic too_many;
    logic last;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/core/scc_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on scc_pkg for the operand width.
module scc_div import scc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder,
  output logic             done
);

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] q, r, dv;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DIV_W:0]   r_sh;
  logic             ge;
  logic [DIV_W-1:0] r_new;

  // One shift-subtract step
  always_comb begin
    r_sh  = {r, q[DIV_W-1]};
    ge    = r_sh >= {1'b0, dv};
    r_new = ge ? DIV_W'(r_sh - {1'b0, dv}) : r_sh[DIV_W-1:0];
  end

  // Iterate over all dividend bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      q    <= dividend;
      r    <= '0;
      dv   <= divisor;
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      q   <= {q[DIV_W-2:0], ge};
      r   <= r_new;
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient  = q;
  assign remainder = r;

endmodule

@@ rtl/core/scc_datapath.sv @@
// Datapath: descriptor, chunk size register, products, divider, chunk
// walker and output register. Depends on scc_pkg and scc_div.
module scc_datapath import scc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  desc_t       in_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        out_valid,
  input  logic        out_ready,
  output chunk_t      out_data
);

  logic [31:0] chunk_bytes;
  desc_t       d;
  logic [63:0] prod_s, prod_d;
  logic [31:0] qa, qb, spc;
  logic [63:0] rem_s, rem_d;
  logic [31:0] step_s, step_d, mult_s, mult_d;
  logic [47:0] off_s, off_d, inc_s, inc_d;
  logic [63:0] inc_prod_s, inc_prod_d;

  logic        su, du, single, src_big;
  logic [31:0] big, little, fl;
  logic        lay_s_ok, lay_d_ok;
  logic [31:0] div_n, div_d, div_q, div_r;
  logic        div_done;
  logic [31:0] m_s, m_d;
  chunk_t      chunk;

  // Hold chunk size register
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= '0;
    end else if (cfg_we) begin
      chunk_bytes <= cfg_wdata;
    end
  end

  // Classify the descriptor
  always_comb begin
    su       = (d.src_stride == d.src_frag_len) || (d.src_frag_count == 32'd1);
    du       = (d.dst_stride == d.dst_frag_len) || (d.dst_frag_count == 32'd1);
    single   = su ^ du;
    src_big  = d.src_frag_len > d.dst_frag_len;
    big      = src_big ? d.src_frag_len : d.dst_frag_len;
    little   = src_big ? d.dst_frag_len : d.src_frag_len;
    fl       = su ? d.dst_frag_len : d.src_frag_len;
    lay_s_ok = (d.src_frag_len != '0) && (d.src_frag_count != '0) &&
               ((d.src_stride >= d.src_frag_len) ||
                ((d.src_stride == '0) && (d.src_frag_count == 32'd1)));
    lay_d_ok = (d.dst_frag_len != '0) && (d.dst_frag_count != '0) &&
               ((d.dst_stride >= d.dst_frag_len) ||
                ((d.dst_stride == '0) && (d.dst_frag_count == 32'd1)));
  end

  // Pick divider operands
  always_comb begin
    unique case (cmd.div_sel)
      DIV_CH_FL: begin
        div_n = chunk_bytes;
        div_d = fl;
      end
      DIV_BIG_SMALL: begin
        div_n = big;
        div_d = little;
      end
      default: begin
        div_n = chunk_bytes;
        div_d = big;
      end
    endcase
  end

  scc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  // Full-width offset steps, wrapped to 48 bits when latched
  assign inc_prod_s = step_s * mult_s;
  assign inc_prod_d = step_d * mult_d;

  // Descriptor, products, quotients and walker setup
  always_ff @(posedge clk) begin
    if (cmd.load_desc) d <= in_data;
    if (cmd.mul_tot) begin
      prod_s <= d.src_frag_len * d.src_frag_count;
      prod_d <= d.dst_frag_len * d.dst_frag_count;
    end
    if (cmd.latch_qa) qa <= div_q;
    if (cmd.latch_qb) qb <= div_q;
    if (cmd.set1) spc <= 32'(qa * qb);
    if (cmd.set2) begin
      off_s <= d.src_offset;
      off_d <= d.dst_offset;
      if (su && du) begin
        rem_s  <= prod_s;
        rem_d  <= prod_s;
        step_s <= chunk_bytes;
        step_d <= chunk_bytes;
        mult_s <= 32'd1;
        mult_d <= 32'd1;
      end else if (single) begin
        rem_s  <= 64'(su ? d.dst_frag_count : d.src_frag_count);
        rem_d  <= 64'(su ? d.dst_frag_count : d.src_frag_count);
        step_s <= qa;
        step_d <= qa;
        mult_s <= su ? d.dst_frag_len : d.src_stride;
        mult_d <= su ? d.dst_stride : d.src_frag_len;
      end else begin
        rem_s  <= 64'(d.src_frag_count);
        rem_d  <= 64'(d.dst_frag_count);
        step_s <= src_big ? qb : spc;
        step_d <= src_big ? spc : qb;
        mult_s <= d.src_stride;
        mult_d <= d.dst_stride;
      end
    end
    if (cmd.set3) begin
      inc_s <= inc_prod_s[47:0];
      inc_d <= inc_prod_d[47:0];
    end
    // Advance the walker after each chunk
    if (cmd.emit && (cmd.out_sel == OUT_CHUNK)) begin
      rem_s <= rem_s - 64'(step_s);
      rem_d <= rem_d - 64'(step_d);
      off_s <= off_s + inc_s;
      off_d <= off_d + inc_d;
    end
  end

  // Build the current chunk
  always_comb begin
    m_s = (rem_s < 64'(step_s)) ? rem_s[31:0] : step_s;
    m_d = (rem_d < 64'(step_d)) ? rem_d[31:0] : step_d;
    chunk                  = '0;
    chunk.chunk_src_offset = off_s;
    chunk.chunk_dst_offset = off_d;
    chunk.last_chunk       = rem_s <= 64'(step_s);
    chunk.status           = ST_OK;
    if (su && du) begin
      chunk.chunk_src_len    = m_s;
      chunk.chunk_src_count  = 32'd1;
      chunk.chunk_src_stride = m_s;
      chunk.chunk_dst_len    = m_d;
      chunk.chunk_dst_count  = 32'd1;
      chunk.chunk_dst_stride = m_d;
    end else begin
      if (single && su) begin
        chunk.chunk_src_len    = inc_s[31:0];
        chunk.chunk_src_count  = 32'd1;
        chunk.chunk_src_stride = '0;
      end else begin
        chunk.chunk_src_len    = d.src_frag_len;
        chunk.chunk_src_count  = m_s;
        chunk.chunk_src_stride = d.src_stride;
      end
      if (single && du) begin
        chunk.chunk_dst_len    = inc_d[31:0];
        chunk.chunk_dst_count  = 32'd1;
        chunk.chunk_dst_stride = '0;
      end else begin
        chunk.chunk_dst_len    = d.dst_frag_len;
        chunk.chunk_dst_count  = m_d;
        chunk.chunk_dst_stride = d.dst_stride;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.out_sel)
        OUT_CHUNK: out_data <= chunk;
        OUT_PASS: begin
          out_data.chunk_src_offset <= d.src_offset;
          out_data.chunk_src_len    <= d.src_frag_len;
          out_data.chunk_src_count  <= d.src_frag_count;
          out_data.chunk_src_stride <= d.src_stride;
          out_data.chunk_dst_offset <= d.dst_offset;
          out_data.chunk_dst_len    <= d.dst_frag_len;
          out_data.chunk_dst_count  <= d.dst_frag_count;
          out_data.chunk_dst_stride <= d.dst_stride;
          out_data.last_chunk       <= 1'b1;
          out_data.status           <= ST_OK;
        end
        default: begin
          out_data            <= '0;
          out_data.last_chunk <= 1'b1;
          out_data.status     <= cmd.err_code;
        end
      endcase
    end
  end

  // Status to the controller
  always_comb begin
    stat.lay_bad    = !lay_s_ok || !lay_d_ok || (prod_s != prod_d);
    stat.ch_zero    = chunk_bytes == '0;
    stat.su         = su;
    stat.du         = du;
    stat.frag_big   = single ? (fl > chunk_bytes) : (big > chunk_bytes);
    stat.div_done   = div_done;
    stat.div_rem_nz = div_r != '0;
    stat.too_many   = rem_s > (64'(step_s) * 64'(MAX_CHUNKS));
    stat.last       = chunk.last_chunk;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

@@ rtl/core/scc_ctrl.sv @@
// Controller state machine: sequences checks, divisions, setup and the
// chunk walk. Depends on scc_pkg.
module scc_ctrl import scc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_CLS  = 4'd2;
  localparam logic [3:0] S_DIV1 = 4'd3;
  localparam logic [3:0] S_DIV2 = 4'd4;
  localparam logic [3:0] S_SET1 = 4'd5;
  localparam logic [3:0] S_SET2 = 4'd6;
  localparam logic [3:0] S_SET3 = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;
  localparam logic [3:0] S_ERR  = 4'd9;
  localparam logic [3:0] S_PASS = 4'd10;

  logic [3:0] state, state_next;
  logic [2:0] err_code, err_code_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    err_code_next = err_code;
    cmd           = '0;
    cmd.out_sel   = OUT_CHUNK;
    cmd.div_sel   = DIV_CH_FL;
    cmd.err_code  = err_code;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_desc = 1'b1;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_tot = 1'b1;
        state_next  = S_CLS;
      end
      S_CLS: begin
        priority if (stat.lay_bad) begin
          err_code_next = ST_LAYOUT;
          state_next    = S_ERR;
        end else if (stat.ch_zero) begin
          state_next = S_PASS;
        end else if (stat.su && stat.du) begin
          state_next = S_SET1;
        end else if (stat.frag_big) begin
          err_code_next = ST_FRAG;
          state_next    = S_ERR;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = (stat.su || stat.du) ? DIV_CH_FL : DIV_BIG_SMALL;
          state_next    = S_DIV1;
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          if (stat.su || stat.du) begin
            cmd.latch_qa = 1'b1;
            state_next   = S_SET1;
          end else if (stat.div_rem_nz) begin
            err_code_next = ST_INCOMPAT;
            state_next    = S_ERR;
          end else begin
            cmd.latch_qa  = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_CH_BIG;
            state_next    = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (stat.div_done) begin
          cmd.latch_qb = 1'b1;
          state_next   = S_SET1;
        end
      end
      S_SET1: begin
        cmd.set1   = 1'b1;
        state_next = S_SET2;
      end
      S_SET2: begin
        cmd.set2   = 1'b1;
        state_next = S_SET3;
      end
      S_SET3: begin
        if (stat.too_many) begin
          err_code_next = ST_MANY;
          state_next    = S_ERR;
        end else begin
          cmd.set3   = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last) state_next = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.out_sel = OUT_ERR;
          state_next  = S_IDLE;
        end
      end
      S_PASS: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.out_sel = OUT_PASS;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      err_code <= ST_OK;
    end else begin
      state    <= state_next;
      err_code <= err_code_next;
    end
  end

  // Never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free) else $error("emit while output busy");

  // Divider starts only from classification or the first division
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (state == S_CLS || state == S_DIV1))
    else $error("divider started in wrong state");

  // Last chunk transfer returns the controller to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && cmd.emit && stat.last) |=> state == S_IDLE)
    else $error("walk did not end on last chunk");

  // Error results always carry a nonzero code
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.out_sel == OUT_ERR) |-> err_code != ST_OK)
    else $error("error result without code");

endmodule

@@ rtl/core/strided_copy_chunker.sv @@
// Strided copy chunker top level: one descriptor in, up to MAX_CHUNKS chunks out.
// Pass-through, layout and fragment-size errors take no division, nor does a copy
// with both sides contiguous; one strided side takes one division, both strided
// take two (incompatible fragments end after the first).
// Chunks then leave at one per cycle while ready. Reset (rst, synchronous)
// clears chunk_bytes to 0, idles the controller and empties the output.
module strided_copy_chunker import scc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  desc_t       in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output chunk_t      out_data
);

  cmd_t  cmd;
  stat_t stat;

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ dv/strided_copy_chunker_checker.sv @@
// Checker for the strided copy chunker: watches the config, input and output
// channels, predicts chunk descriptors and compares them. Depends on scc_pkg.
`timescale 1ns / 100ps
module strided_copy_chunker_checker import scc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  desc_t       in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  chunk_t      out_data,
  output int          errors,
  output int          pending
);

  localparam logic [2:0] ST_INDEX = 3'd4;

  logic [31:0] chunk_limit;
  chunk_t      expected_chunks[$];
  chunk_t      staged[$];

  // Append one chunk to the staging list
  function automatic void stage(bit [63:0] so, bit [63:0] sl, bit [63:0] sc, bit [63:0] ss,
                                bit [63:0] dof, bit [63:0] dl, bit [63:0] dc,
                                bit [63:0] ds);
    chunk_t c;
    c = '0;
    c.chunk_src_offset = so[47:0];
    c.chunk_src_len    = sl[31:0];
    c.chunk_src_count  = sc[31:0];
    c.chunk_src_stride = ss[31:0];
    c.chunk_dst_offset = dof[47:0];
    c.chunk_dst_len    = dl[31:0];
    c.chunk_dst_count  = dc[31:0];
    c.chunk_dst_stride = ds[31:0];
    c.status           = ST_OK;
    staged = {staged, c};
  endfunction

  // Replace the staged chunks by a single error result
  function automatic void stage_error(logic [2:0] code);
    chunk_t c;
    c = '0;
    c.last_chunk = 1'b1;
    c.status     = code;
    staged.delete();
    staged = {staged, c};
  endfunction

  function automatic bit layout_good(bit [63:0] len, bit [63:0] cnt, bit [63:0] str);
    return len > 0 && cnt > 0 && (str >= len || (str == 0 && cnt == 1));
  endfunction

  function automatic bit [63:0] div_up(bit [63:0] a, bit [63:0] b);
    return a / b + ((a % b != 0) ? 64'd1 : 64'd0);
  endfunction

  // Split one descriptor into chunks, leaving the result in staged
  function automatic void split_descriptor(desc_t d, bit [63:0] ch);
    bit [63:0] so, sl, sc, ss, dof, dl, dc, ds;
    bit [63:0] n, total, start, len, fl, fc, fs, fo, uo, fpc, nbytes, stop, num;
    bit [63:0] big, little, lpc, ratio, spc, cl, s0, s1, t0, t1;
    bit        su, du;
    chunk_t    c;
    so = d.src_offset;   sl = d.src_frag_len; sc = d.src_frag_count; ss = d.src_stride;
    dof = d.dst_offset;  dl = d.dst_frag_len; dc = d.dst_frag_count; ds = d.dst_stride;
    staged.delete();
    if (!layout_good(sl, sc, ss) || !layout_good(dl, dc, ds) || sl * sc != dl * dc) begin
      stage_error(ST_LAYOUT);
      return;
    end
    if (ch == 0) begin
      stage(so, sl, sc, ss, dof, dl, dc, ds);
      staged[0].last_chunk = 1'b1;
      return;
    end
    su = (ss == sl) || (sc == 1);
    du = (ds == dl) || (dc == 1);
    if (su && du) begin
      total = sl * sc;
      n = div_up(total, ch);
      if (n > MAX_CHUNKS) begin
        stage_error(ST_MANY);
        return;
      end
      for (bit [63:0] i = 0; i < n; i++) begin
        start = i * ch;
        len = (total - start < ch) ? total - start : ch;
        stage(so + start, len, 1, len, dof + start, len, 1, len);
      end
    end else if (su || du) begin
      // one side strided: cut on its fragments
      fl = su ? dl : sl;  fc = su ? dc : sc;  fs = su ? ds : ss;
      fo = su ? dof : so; uo = su ? so : dof;
      if (fl > ch) begin
        stage_error(ST_FRAG);
        return;
      end
      fpc = ch / fl;
      n = div_up(fc, fpc);
      if (n > MAX_CHUNKS) begin
        stage_error(ST_MANY);
        return;
      end
      nbytes = fl * fpc;
      for (bit [63:0] i = 0; i < n; i++) begin
        start = i * fpc;
        stop = (fc - start < fpc) ? fc : start + fpc;
        num = stop - start;
        if (su) stage(uo + start * fl, nbytes, 1, 0, fo + start * fs, fl, num, fs);
        else    stage(fo + start * fs, fl, num, fs, uo + start * fl, nbytes, 1, 0);
      end
    end else begin
      // both strided: cut on the larger fragments
      big = (sl > dl) ? sl : dl;
      little = (sl > dl) ? dl : sl;
      if (big > ch) begin
        stage_error(ST_FRAG);
        return;
      end
      if (big % little != 0) begin
        stage_error(ST_INCOMPAT);
        return;
      end
      lpc = ch / big;
      ratio = big / little;
      spc = lpc * ratio;
      cl = (sc < dc) ? sc : dc;
      n = div_up(cl, lpc);
      if (n > MAX_CHUNKS) begin
        stage_error(ST_MANY);
        return;
      end
      for (bit [63:0] i = 0; i < n; i++) begin
        if (sl > dl) begin
          s0 = i * lpc;
          if (s0 >= sc) begin
            stage_error(ST_INDEX);
            return;
          end
          s1 = (sc - s0 < lpc) ? sc : s0 + lpc;
          t0 = s0 * ratio;
          if (t0 >= dc) begin
            stage_error(ST_INDEX);
            return;
          end
          t1 = s1 * ratio;
          stage(so + s0 * ss, big, s1 - s0, ss, dof + t0 * ds, little, t1 - t0, ds);
        end else begin
          s0 = i * spc;
          if (s0 >= sc) begin
            stage_error(ST_INDEX);
            return;
          end
          s1 = (sc - s0 < spc) ? sc : s0 + spc;
          t0 = s0 / ratio;
          if (t0 >= dc) begin
            stage_error(ST_INDEX);
            return;
          end
          t1 = s1 / ratio;
          stage(so + s0 * ss, little, s1 - s0, ss, dof + t0 * ds, big, t1 - t0, ds);
        end
      end
    end
    c = staged[$];
    c.last_chunk = 1'b1;
    staged[$] = c;
  endfunction

  function automatic void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  assign pending = expected_chunks.size();

  // Track config, predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    chunk_t e;
    if (rst) begin
      chunk_limit <= '0;
      errors = 0;
    end else begin
      if (cfg_we) chunk_limit <= cfg_wdata;
      if (in_valid && in_ready) begin
        split_descriptor(in_data, {32'd0, chunk_limit});
        foreach (staged[k]) expected_chunks = {expected_chunks, staged[k]};
      end
      if (out_valid && out_ready) begin
        if (expected_chunks.size() == 0) begin
          $error("unexpected chunk transfer 0x%0h", out_data);
          errors++;
        end else begin
          e = expected_chunks.pop_front();
          cmp("chunk_src_offset", e.chunk_src_offset, out_data.chunk_src_offset);
          cmp("chunk_src_len", e.chunk_src_len, out_data.chunk_src_len);
          cmp("chunk_src_count", e.chunk_src_count, out_data.chunk_src_count);
          cmp("chunk_src_stride", e.chunk_src_stride, out_data.chunk_src_stride);
          cmp("chunk_dst_offset", e.chunk_dst_offset, out_data.chunk_dst_offset);
          cmp("chunk_dst_len", e.chunk_dst_len, out_data.chunk_dst_len);
          cmp("chunk_dst_count", e.chunk_dst_count, out_data.chunk_dst_count);
          cmp("chunk_dst_stride", e.chunk_dst_stride, out_data.chunk_dst_stride);
          cmp("last_chunk", e.last_chunk, out_data.last_chunk);
          cmp("status", e.status, out_data.status);
        end
      end
    end
  end

endmodule

@@ dv/strided_copy_chunker_tb.sv @@
// Testbench top for the strided copy chunker: drives config and descriptors,
// stalls the output, gives the verdict. Depends on scc_pkg and the checker.
`timescale 1ns / 100ps
module strided_copy_chunker_tb;
  import scc_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic   clk;
  logic   rst;
  logic   cfg_we;
  logic [31:0] cfg_wdata;
  logic   in_valid;
  logic   in_ready;
  desc_t  in_data;
  logic   out_valid;
  logic   out_ready;
  chunk_t out_data;
  int     errors;
  int     pending;
  int     idle_cycles;
  int     burst_left;
  int     stall_phase;

  strided_copy_chunker DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  strided_copy_chunker_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: long always-ready stretches alternate with random stalls
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) out_ready <= 1'b1;
    else if ((stall_phase / 300) % 3 == 0) out_ready <= 1'b1;
    else if ((stall_phase / 300) % 3 == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 7) == 0);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [47:0] rand_offset();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic desc_t make_desc(logic [47:0] so, logic [31:0] sl, logic [31:0] sc,
                                      logic [31:0] ss, logic [47:0] dof, logic [31:0] dl,
                                      logic [31:0] dc, logic [31:0] ds);
    desc_t d;
    d.src_offset = so; d.src_frag_len = sl; d.src_frag_count = sc; d.src_stride = ss;
    d.dst_offset = dof; d.dst_frag_len = dl; d.dst_frag_count = dc; d.dst_stride = ds;
    return d;
  endfunction

  // Random descriptor, mostly well-formed, for each of the copy shapes
  function automatic desc_t rand_desc();
    int unsigned a, b, s, r, c, pick;
    logic [31:0] w;
    pick = $urandom_range(0, 11);
    a = $urandom_range(1, 16);
    b = $urandom_range(2, 40);
    s = $urandom_range(1, 16);
    r = $urandom_range(1, 4);
    c = $urandom_range(1, 20);
    case (pick)
      0, 1: begin
        return make_desc(rand_offset(), a, b, a, rand_offset(), a * b, 1, $urandom());
      end
      2: begin
        w = $urandom();
        if (w == 0) w = 1;
        return make_desc(rand_offset(), w, 1, $urandom(), rand_offset(), w, 1, $urandom());
      end
      3, 4: begin
        return make_desc(rand_offset(), a * b, 1, 0, rand_offset(), a, b,
                         a + $urandom_range(1, 64));
      end
      5, 6: begin
        return make_desc(rand_offset(), a, b, a + $urandom_range(1, 64),
                         rand_offset(), a * b, 1, 0);
      end
      7, 8: begin
        return make_desc(rand_offset(), s * r, c + 1, s * r + $urandom_range(1, 8),
                         rand_offset(), s, (c + 1) * r, s + $urandom_range(1, 8));
      end
      9: begin
        return make_desc(rand_offset(), s, (c + 1) * r, s + $urandom_range(1, 8),
                         rand_offset(), s * r, c + 1, s * r + $urandom_range(1, 8));
      end
      10: begin
        return make_desc(rand_offset(), 6, 2 * c, 8, rand_offset(), 4, 3 * c, 5);
      end
      default: begin
        return make_desc(rand_offset(), $urandom(), $urandom(), $urandom(),
                         rand_offset(), $urandom(), $urandom(), $urandom());
      end
    endcase
  endfunction

  // Present one descriptor and hold it until the transfer
  task automatic send(desc_t d);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed();
    send(make_desc('0, 0, 0, 0, '0, 0, 0, 0));
    send(make_desc('1, '1, 1, '1, '1, '1, 1, '1));
    send(make_desc('1, '1, '1, '1, '1, '1, '1, '1));
    send(make_desc(48'h10, 4, 1, 0, 48'h20, 2, 2, 2));
    send(make_desc(48'h10, 4, 2, 3, 48'h20, 8, 1, 8));
    send(make_desc(48'h10, 4, 2, 4, 48'h20, 4, 3, 4));
    send(make_desc(48'h0, 0, 1, 0, 48'h0, 0, 1, 0));
    send(make_desc(48'h0, 4, 2, 0, 48'h0, 8, 1, 8));
    send(make_desc(48'h100, 40, 1, 40, 48'h200, 4, 10, 9));
    send(make_desc(48'h100, 4, 10, 9, 48'h200, 40, 1, 40));
    send(make_desc(48'h100, 8, 4, 12, 48'h200, 2, 16, 5));
    send(make_desc(48'h100, 2, 16, 5, 48'h200, 8, 4, 12));
    send(make_desc(48'h100, 6, 2, 8, 48'h200, 4, 3, 5));
    send(make_desc(48'h100, 128, 2, 200, 48'h200, 64, 4, 70));
    send(make_desc(48'h100, 1, 4096, 1, 48'h200, 4096, 1, 0));
    send(make_desc(48'h100, 1, 4096, 2, 48'h200, 4096, 1, 0));
    send(make_desc(48'hFFFF_FFFF_FFF0, 16, 4, 32, 48'hFFFF_FFFF_FFF0, 64, 1, 64));
  endtask

  initial begin
    logic [31:0] limits[10];
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b1;
    stall_phase = 0;
    burst_left = 0;
    limits = '{32'd0, 32'd64, 32'd1, 32'd7, 32'd256, 32'd1000, 32'hFFFF_FFFF,
               32'd4096, 32'd48, 32'd0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed descriptors with chunking off and on
    directed();
    drain();
    write_limit(32'd64);
    directed();
    drain();

    // Random phases across chunk sizes, extremes included
    foreach (limits[p]) begin
      write_limit(p == 9 ? $urandom_range(8, 512) : limits[p]);
      repeat (40) send(rand_desc());
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
